FILE: hdl/atcm_pkg.sv
// Shared types and constants of the tile collision mover.
package atcm_pkg;

    typedef enum logic [1:0] {
        CMD_WR_TILE = 2'd0,
        CMD_WR_OBS  = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_MOVE    = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_TILE_SIZE  = 3'd0;
    localparam logic [2:0] REG_GRID_COLS  = 3'd1;
    localparam logic [2:0] REG_GRID_ROWS  = 3'd2;
    localparam logic [2:0] REG_OBS_COUNT  = 3'd3;
    localparam logic [2:0] REG_MAX_PROBE  = 3'd4;
    localparam logic [2:0] REG_CORR_STEP  = 3'd5;

    // Width of box edges inside the collision unit.
    localparam int EW = 19;

    typedef struct packed {
        logic [6:0] tile_size;
        logic [6:0] grid_columns;
        logic [6:0] grid_rows;
        logic [4:0] obstacle_count;
    } hit_cfg_t;

    typedef struct packed {
        logic               start;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [12:0]        w;
        logic [12:0]        h;
    } hit_req_t;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [12:0] count;
    } hit_rsp_t;

    typedef struct packed {
        logic [12:0]        h;
        logic [12:0]        w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } obs_t;

endpackage

FILE: hdl/atcm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module atcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/atcm_hit.sv
// Box collision test against the solid tile map and the obstacle table.
module atcm_hit import atcm_pkg::*; #(
    parameter int MAP_COLUMNS = 64,
    parameter int MAP_ROWS = 64,
    parameter int MAX_OBSTACLES = 16,
    localparam int TILES = MAP_COLUMNS * MAP_ROWS,
    localparam int TAW = (TILES > 1) ? $clog2(TILES) : 1,
    localparam int OAW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  hit_cfg_t       cfg,
    input  hit_req_t       req,
    output hit_rsp_t       rsp,
    input  logic           tile_we,
    input  logic [TAW-1:0] tile_waddr,
    input  logic           tile_wdata,
    input  logic           obs_we,
    input  logic [OAW-1:0] obs_waddr,
    input  obs_t           obs_wdata
);

    localparam int CW = $clog2(MAP_COLUMNS + 1);
    localparam int RW = $clog2(MAP_ROWS + 1);
    localparam int OCW = $clog2(MAX_OBSTACLES + 1);
    localparam int BW = TAW + 1;

    typedef enum logic [2:0] {
        H_IDLE, H_BOUND, H_DIV, H_BASE, H_TRD, H_TCHK, H_ORD, H_OCHK
    } hstate_t;

    hstate_t state_reg;

    logic [CW-1:0]  cols_eff;
    logic [RW-1:0]  rows_eff;
    logic [OCW-1:0] oc_eff;
    logic [6:0]     ts_eff;
    logic signed [EW-1:0] world_w, world_h;

    logic signed [EW-1:0] x_reg, y_reg, right_reg, bottom_reg;
    logic signed [EW-1:0] right_m1, bottom_m1;

    logic [1:0]  div_sel_reg;
    logic [3:0]  div_cnt_reg;
    logic [15:0] div_num_reg;
    logic [6:0]  div_rem_reg;
    logic [15:0] div_quo_reg;
    logic [7:0]  div_rem_sh;
    logic        div_bit;
    logic [6:0]  div_rem_next;
    logic [15:0] div_quo_next;
    logic [15:0] div_src [4];

    logic [CW-1:0]  tx0_reg, tx1_reg, tx_reg;
    logic [RW-1:0]  ty0_reg, ty1_reg, ty_reg;
    logic [BW-1:0]  base_reg;
    logic [OCW-1:0] oi_reg;
    logic [12:0]    count_reg;
    logic           done_reg, hit_reg;

    logic [TAW-1:0] tile_raddr;
    logic [0:0]     tile_rdata;
    logic [OAW-1:0] obs_raddr;
    obs_t           obs_rdata;

    logic signed [EW-1:0] ox, oy, oxr, oyb;
    logic                 obs_hit;

    assign cols_eff = (int'(cfg.grid_columns) > MAP_COLUMNS) ? CW'(MAP_COLUMNS)
                                                            : CW'(cfg.grid_columns);
    assign rows_eff = (int'(cfg.grid_rows) > MAP_ROWS) ? RW'(MAP_ROWS) : RW'(cfg.grid_rows);
    assign oc_eff = (int'(cfg.obstacle_count) > MAX_OBSTACLES) ? OCW'(MAX_OBSTACLES)
                                                              : OCW'(cfg.obstacle_count);
    assign ts_eff = (cfg.tile_size == 7'd0) ? 7'd1 : cfg.tile_size;
    assign world_w = $signed(EW'(cols_eff * ts_eff));
    assign world_h = $signed(EW'(rows_eff * ts_eff));

    assign right_m1 = right_reg - EW'(1);
    assign bottom_m1 = bottom_reg - EW'(1);

    assign div_src[0] = x_reg[15:0];
    assign div_src[1] = right_m1[15:0];
    assign div_src[2] = y_reg[15:0];
    assign div_src[3] = bottom_m1[15:0];

    assign div_rem_sh = {div_rem_reg, div_num_reg[15]};
    assign div_bit = (div_rem_sh >= {1'b0, ts_eff});
    assign div_rem_next = div_bit ? 7'(div_rem_sh - {1'b0, ts_eff}) : div_rem_sh[6:0];
    assign div_quo_next = {div_quo_reg[14:0], div_bit};

    assign tile_raddr = TAW'(base_reg + BW'(tx_reg));
    assign obs_raddr = OAW'(oi_reg);

    assign ox = EW'(obs_rdata.x);
    assign oy = EW'(obs_rdata.y);
    assign oxr = ox + $signed(EW'(obs_rdata.w));
    assign oyb = oy + $signed(EW'(obs_rdata.h));
    assign obs_hit = (x_reg < oxr) && (right_reg > ox) && (y_reg < oyb) && (bottom_reg > oy);

    atcm_ram #(.WIDTH(1), .DEPTH(TILES)) u_tile_ram (
        .aclk  (aclk),
        .we    (tile_we),
        .waddr (tile_waddr),
        .wdata (tile_wdata),
        .raddr (tile_raddr),
        .rdata (tile_rdata)
    );

    atcm_ram #(.WIDTH($bits(obs_t)), .DEPTH(MAX_OBSTACLES)) u_obs_ram (
        .aclk  (aclk),
        .we    (obs_we),
        .waddr (obs_waddr),
        .wdata (obs_wdata),
        .raddr (obs_raddr),
        .rdata (obs_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                H_IDLE: begin
                    done_reg <= 1'b0;
                    if (req.start) begin
                        x_reg <= EW'(req.x);
                        y_reg <= EW'(req.y);
                        right_reg <= EW'(req.x) + $signed(EW'(req.w));
                        bottom_reg <= EW'(req.y) + $signed(EW'(req.h));
                        state_reg <= H_BOUND;
                    end
                end
                H_BOUND: begin
                    if (x_reg < 0 || y_reg < 0 || right_reg > world_w
                            || bottom_reg > world_h) begin
                        done_reg <= 1'b1;
                        hit_reg <= 1'b1;
                        count_reg <= 13'd1;
                        state_reg <= H_IDLE;
                    end else begin
                        div_sel_reg <= 2'd0;
                        div_cnt_reg <= 4'd0;
                        div_num_reg <= div_src[0];
                        div_rem_reg <= 7'd0;
                        state_reg <= H_DIV;
                    end
                end
                H_DIV: begin
                    div_rem_reg <= div_rem_next;
                    div_quo_reg <= div_quo_next;
                    div_num_reg <= {div_num_reg[14:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15) begin
                        unique case (div_sel_reg)
                            2'd0: tx0_reg <= CW'(div_quo_next);
                            2'd1: tx1_reg <= CW'(div_quo_next);
                            2'd2: ty0_reg <= RW'(div_quo_next);
                            default: ty1_reg <= RW'(div_quo_next);
                        endcase
                        if (div_sel_reg == 2'd3) begin
                            state_reg <= H_BASE;
                        end else begin
                            div_sel_reg <= div_sel_reg + 2'd1;
                            div_num_reg <= div_src[div_sel_reg + 2'd1];
                            div_rem_reg <= 7'd0;
                            div_cnt_reg <= 4'd0;
                        end
                    end
                end
                H_BASE: begin
                    base_reg <= BW'(ty0_reg * cols_eff);
                    tx_reg <= tx0_reg;
                    ty_reg <= ty0_reg;
                    count_reg <= 13'd0;
                    state_reg <= H_TRD;
                end
                H_TRD: begin
                    state_reg <= H_TCHK;
                end
                H_TCHK: begin
                    count_reg <= count_reg + 13'd1;
                    if (tile_rdata[0]) begin
                        done_reg <= 1'b1;
                        hit_reg <= 1'b1;
                        state_reg <= H_IDLE;
                    end else if (tx_reg == tx1_reg) begin
                        if (ty_reg == ty1_reg) begin
                            if (oc_eff == '0) begin
                                done_reg <= 1'b1;
                                hit_reg <= 1'b0;
                                state_reg <= H_IDLE;
                            end else begin
                                oi_reg <= '0;
                                state_reg <= H_ORD;
                            end
                        end else begin
                            ty_reg <= ty_reg + RW'(1);
                            tx_reg <= tx0_reg;
                            base_reg <= base_reg + BW'(cols_eff);
                            state_reg <= H_TRD;
                        end
                    end else begin
                        tx_reg <= tx_reg + CW'(1);
                        state_reg <= H_TRD;
                    end
                end
                H_ORD: begin
                    state_reg <= H_OCHK;
                end
                H_OCHK: begin
                    count_reg <= count_reg + 13'd1;
                    if (obs_hit) begin
                        done_reg <= 1'b1;
                        hit_reg <= 1'b1;
                        state_reg <= H_IDLE;
                    end else if (oi_reg + OCW'(1) == oc_eff) begin
                        done_reg <= 1'b1;
                        hit_reg <= 1'b0;
                        state_reg <= H_IDLE;
                    end else begin
                        oi_reg <= oi_reg + OCW'(1);
                        state_reg <= H_ORD;
                    end
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hit = hit_reg;
    assign rsp.count = count_reg;

endmodule

FILE: hdl/aabb_tile_collision_mover.sv
// Top level of the tile collision mover: command sequencer, move walker and ports.
//
//  Channel  Ports          Direction  Carries
//  input    s_axis_*       in         one command word with its box and move
//  result   m_axis_*       out        one result word per command
//  config   cfg_*          in         register writes, no read-back
//
// A query checks the box against the world bounds, then each tile it covers and then each
// obstacle, and stops at the first hit; a move runs one such query for every pixel step
// and probe.
// The work is set by the single collision unit, its shared bit-serial divider and
// the one read port of each map memory. After reset a clearing pass zeroes the tile
// map before the first word is taken.
// A stalled result is held in the output register while the next word is taken; the
// result of that word waits until the register is free.
module aabb_tile_collision_mover import atcm_pkg::*; #(
    parameter int MAP_COLUMNS = 64,
    parameter int MAP_ROWS = 64,
    parameter int MAX_OBSTACLES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, box_width, box_height, move_x, move_y, entry_index, tile_solid
    input  logic [103:0] s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // collides, cells_tested, moved_x, moved_y, blocked_x, blocked_y, new_x, new_y,
    // bad_request
    output logic [79:0]  m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_wr_data
);

    localparam int TILES = MAP_COLUMNS * MAP_ROWS;
    localparam int TAW = (TILES > 1) ? $clog2(TILES) : 1;
    localparam int OAW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_QWAIT, S_WSTEP, S_WWAIT, S_WRET, S_PTEST, S_PWAIT, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        PH_MX, PH_MY, PH_PN, PH_PP, PH_SL
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [6:0] tile_size_reg, grid_columns_reg, grid_rows_reg;
    logic [4:0] obstacle_count_reg;
    logic [7:0] max_probe_reg, corr_step_reg;
    logic [7:0] cs_eff;

    cmd_t               in_cmd;
    logic signed [15:0] in_pos_x, in_pos_y;
    logic [12:0]        in_w, in_h;
    logic signed [12:0] in_move_x, in_move_y;
    logic [11:0]        in_index;
    logic               in_solid;
    logic               accept;

    logic [TAW-1:0] clr_addr_reg;
    logic           tile_we;
    logic [TAW-1:0] tile_waddr;
    logic           tile_wdata;
    logic           obs_we;
    obs_t           obs_wdata;

    hit_cfg_t hcfg;
    hit_req_t hreq_reg;
    hit_rsp_t hrsp;

    logic signed [15:0] cur_x_reg, cur_y_reg, wk_x_reg, wk_y_reg;
    logic [12:0]        bw_reg, bh_reg;
    logic signed [12:0] dx_reg, dy_reg;
    logic signed [13:0] rmx_reg, rmy_reg, wk_req_reg, wk_moved_reg;
    logic               rbx_reg, rby_reg, wk_horiz_reg, wk_blk_reg;
    logic               res_col_reg, res_bad_reg, res_move_reg;
    logic [12:0]        res_cnt_reg;
    logic               slide_hz_reg, pneg_reg, pr_neg_reg;
    logic [7:0]         pr_d_reg;
    logic               m_valid_reg;
    logic [79:0]        m_data_reg;

    logic signed [15:0] wk_coord;
    logic signed [16:0] wk_step, wk_coord_next, pstep;
    logic               wk_ovf;
    logic signed [13:0] wk_step14;
    logic signed [16:0] cand_x, cand_y, probe_x, probe_y;
    logic               hz, vt;
    logic [7:0]         slide_mag, pr_d_inc;
    logic signed [13:0] slide_req, d_req_pos, d_inc_req_neg;
    logic signed [15:0] out_x, out_y;

    assign in_cmd = cmd_t'(s_axis_tuser);
    assign in_pos_x = s_axis_tdata[15:0];
    assign in_pos_y = s_axis_tdata[31:16];
    assign in_w = s_axis_tdata[44:32];
    assign in_h = s_axis_tdata[57:45];
    assign in_move_x = s_axis_tdata[70:58];
    assign in_move_y = s_axis_tdata[83:71];
    assign in_index = s_axis_tdata[95:84];
    assign in_solid = s_axis_tdata[96];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_size_reg <= 7'd16;
            grid_columns_reg <= 7'd64;
            grid_rows_reg <= 7'd64;
            obstacle_count_reg <= 5'd0;
            max_probe_reg <= 8'd0;
            corr_step_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TILE_SIZE: tile_size_reg <= cfg_wr_data[6:0];
                REG_GRID_COLS: grid_columns_reg <= cfg_wr_data[6:0];
                REG_GRID_ROWS: grid_rows_reg <= cfg_wr_data[6:0];
                REG_OBS_COUNT: obstacle_count_reg <= cfg_wr_data[4:0];
                REG_MAX_PROBE: max_probe_reg <= cfg_wr_data;
                REG_CORR_STEP: corr_step_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cs_eff = (corr_step_reg == 8'd0) ? 8'd1 : corr_step_reg;

    assign hcfg.tile_size = tile_size_reg;
    assign hcfg.grid_columns = grid_columns_reg;
    assign hcfg.grid_rows = grid_rows_reg;
    assign hcfg.obstacle_count = obstacle_count_reg;

    assign tile_we = (state_reg == S_CLEAR)
                     || (accept && in_cmd == CMD_WR_TILE && int'(in_index) < TILES);
    assign tile_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : TAW'(in_index);
    assign tile_wdata = (state_reg == S_CLEAR) ? 1'b0 : in_solid;
    assign obs_we = accept && in_cmd == CMD_WR_OBS && int'(in_index) < MAX_OBSTACLES;
    assign obs_wdata.x = in_pos_x;
    assign obs_wdata.y = in_pos_y;
    assign obs_wdata.w = in_w;
    assign obs_wdata.h = in_h;

    atcm_hit #(
        .MAP_COLUMNS   (MAP_COLUMNS),
        .MAP_ROWS      (MAP_ROWS),
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_hit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (hcfg),
        .req        (hreq_reg),
        .rsp        (hrsp),
        .tile_we    (tile_we),
        .tile_waddr (tile_waddr),
        .tile_wdata (tile_wdata),
        .obs_we     (obs_we),
        .obs_waddr  (OAW'(in_index)),
        .obs_wdata  (obs_wdata)
    );

    assign wk_coord = wk_horiz_reg ? wk_x_reg : wk_y_reg;
    assign wk_step = wk_req_reg[13] ? -17'sd1 : 17'sd1;
    assign wk_step14 = wk_req_reg[13] ? -14'sd1 : 14'sd1;
    assign wk_coord_next = 17'(wk_coord) + wk_step;
    assign wk_ovf = wk_coord_next[16] ^ wk_coord_next[15];
    assign cand_x = wk_horiz_reg ? wk_coord_next : 17'(wk_x_reg);
    assign cand_y = wk_horiz_reg ? 17'(wk_y_reg) : wk_coord_next;

    assign pstep = pneg_reg ? -17'sd1 : 17'sd1;
    assign probe_x = 17'(wk_x_reg) + (slide_hz_reg ? pstep : 17'sd0);
    assign probe_y = 17'(wk_y_reg) + (slide_hz_reg ? 17'sd0 : pstep);

    assign hz = (dx_reg != '0) && (dy_reg == '0) && rbx_reg;
    assign vt = (dy_reg != '0) && (dx_reg == '0) && wk_blk_reg;

    assign slide_mag = (pr_d_reg < cs_eff) ? pr_d_reg : cs_eff;
    assign slide_req = pr_neg_reg ? -$signed({6'd0, slide_mag}) : $signed({6'd0, slide_mag});
    assign d_req_pos = $signed({6'd0, pr_d_reg});
    assign pr_d_inc = pr_d_reg + 8'd1;
    assign d_inc_req_neg = -$signed({6'd0, pr_d_inc});

    assign out_x = res_move_reg ? cur_x_reg : 16'sd0;
    assign out_y = res_move_reg ? cur_y_reg : 16'sd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_addr_reg <= '0;
            hreq_reg.start <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + TAW'(1);
                    if (clr_addr_reg == TAW'(TILES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        cur_x_reg <= in_pos_x;
                        cur_y_reg <= in_pos_y;
                        bw_reg <= in_w;
                        bh_reg <= in_h;
                        dx_reg <= in_move_x;
                        dy_reg <= in_move_y;
                        rmx_reg <= '0;
                        rmy_reg <= '0;
                        rbx_reg <= 1'b0;
                        rby_reg <= 1'b0;
                        res_col_reg <= 1'b0;
                        res_cnt_reg <= '0;
                        res_bad_reg <= 1'b0;
                        res_move_reg <= 1'b0;
                        if (in_cmd == CMD_WR_TILE || in_cmd == CMD_WR_OBS) begin
                            state_reg <= S_FIN;
                        end else if (in_w == '0 || in_h == '0) begin
                            res_bad_reg <= 1'b1;
                            res_move_reg <= (in_cmd == CMD_MOVE);
                            state_reg <= S_FIN;
                        end else if (in_cmd == CMD_QUERY) begin
                            hreq_reg.start <= 1'b1;
                            hreq_reg.x <= 17'(in_pos_x);
                            hreq_reg.y <= 17'(in_pos_y);
                            hreq_reg.w <= in_w;
                            hreq_reg.h <= in_h;
                            state_reg <= S_QWAIT;
                        end else begin
                            res_move_reg <= 1'b1;
                            wk_x_reg <= in_pos_x;
                            wk_y_reg <= in_pos_y;
                            wk_horiz_reg <= 1'b1;
                            wk_req_reg <= 14'(in_move_x);
                            wk_moved_reg <= '0;
                            wk_blk_reg <= 1'b0;
                            phase_reg <= PH_MX;
                            state_reg <= S_WSTEP;
                        end
                    end
                end
                S_QWAIT: begin
                    hreq_reg.start <= 1'b0;
                    if (hrsp.done) begin
                        res_col_reg <= hrsp.hit;
                        res_cnt_reg <= hrsp.count;
                        state_reg <= S_FIN;
                    end
                end
                S_WSTEP: begin
                    if (wk_req_reg == '0) begin
                        state_reg <= S_WRET;
                    end else if (wk_ovf) begin
                        wk_blk_reg <= 1'b1;
                        state_reg <= S_WRET;
                    end else begin
                        hreq_reg.start <= 1'b1;
                        hreq_reg.x <= cand_x;
                        hreq_reg.y <= cand_y;
                        hreq_reg.w <= bw_reg;
                        hreq_reg.h <= bh_reg;
                        state_reg <= S_WWAIT;
                    end
                end
                S_WWAIT: begin
                    hreq_reg.start <= 1'b0;
                    if (hrsp.done) begin
                        if (hrsp.hit) begin
                            wk_blk_reg <= 1'b1;
                            state_reg <= S_WRET;
                        end else begin
                            if (wk_horiz_reg) begin
                                wk_x_reg <= wk_coord_next[15:0];
                            end else begin
                                wk_y_reg <= wk_coord_next[15:0];
                            end
                            wk_moved_reg <= wk_moved_reg + wk_step14;
                            wk_req_reg <= wk_req_reg - wk_step14;
                            state_reg <= S_WSTEP;
                        end
                    end
                end
                S_WRET: begin
                    unique case (phase_reg)
                        PH_MX: begin
                            cur_x_reg <= wk_x_reg;
                            rmx_reg <= wk_moved_reg;
                            rbx_reg <= wk_blk_reg;
                            wk_horiz_reg <= 1'b0;
                            wk_req_reg <= 14'(dy_reg);
                            wk_moved_reg <= '0;
                            wk_blk_reg <= 1'b0;
                            phase_reg <= PH_MY;
                            state_reg <= S_WSTEP;
                        end
                        PH_MY: begin
                            cur_y_reg <= wk_y_reg;
                            rmy_reg <= wk_moved_reg;
                            rby_reg <= wk_blk_reg;
                            if (max_probe_reg == 8'd0 || !(hz || vt)) begin
                                state_reg <= S_FIN;
                            end else begin
                                slide_hz_reg <= hz;
                                pneg_reg <= hz ? dx_reg[12] : dy_reg[12];
                                pr_d_reg <= 8'd1;
                                pr_neg_reg <= 1'b1;
                                wk_horiz_reg <= !hz;
                                wk_req_reg <= -14'sd1;
                                wk_moved_reg <= '0;
                                wk_blk_reg <= 1'b0;
                                phase_reg <= PH_PN;
                                state_reg <= S_WSTEP;
                            end
                        end
                        PH_PN: begin
                            if (wk_blk_reg) begin
                                pr_neg_reg <= 1'b0;
                                wk_x_reg <= cur_x_reg;
                                wk_y_reg <= cur_y_reg;
                                wk_req_reg <= d_req_pos;
                                wk_moved_reg <= '0;
                                wk_blk_reg <= 1'b0;
                                phase_reg <= PH_PP;
                                state_reg <= S_WSTEP;
                            end else begin
                                state_reg <= S_PTEST;
                            end
                        end
                        PH_PP: begin
                            if (!wk_blk_reg) begin
                                state_reg <= S_PTEST;
                            end else if (pr_d_reg == max_probe_reg) begin
                                state_reg <= S_FIN;
                            end else begin
                                pr_d_reg <= pr_d_inc;
                                pr_neg_reg <= 1'b1;
                                wk_x_reg <= cur_x_reg;
                                wk_y_reg <= cur_y_reg;
                                wk_req_reg <= d_inc_req_neg;
                                wk_moved_reg <= '0;
                                wk_blk_reg <= 1'b0;
                                phase_reg <= PH_PN;
                                state_reg <= S_WSTEP;
                            end
                        end
                        default: begin
                            cur_x_reg <= wk_x_reg;
                            cur_y_reg <= wk_y_reg;
                            if (slide_hz_reg) begin
                                rmy_reg <= rmy_reg + wk_moved_reg;
                                rby_reg <= rby_reg | wk_blk_reg;
                            end else begin
                                rmx_reg <= rmx_reg + wk_moved_reg;
                                rbx_reg <= rbx_reg | wk_blk_reg;
                            end
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_PTEST: begin
                    hreq_reg.start <= 1'b1;
                    hreq_reg.x <= probe_x;
                    hreq_reg.y <= probe_y;
                    hreq_reg.w <= bw_reg;
                    hreq_reg.h <= bh_reg;
                    state_reg <= S_PWAIT;
                end
                S_PWAIT: begin
                    hreq_reg.start <= 1'b0;
                    if (hrsp.done) begin
                        wk_x_reg <= cur_x_reg;
                        wk_y_reg <= cur_y_reg;
                        wk_moved_reg <= '0;
                        wk_blk_reg <= 1'b0;
                        if (!hrsp.hit) begin
                            wk_req_reg <= slide_req;
                            phase_reg <= PH_SL;
                            state_reg <= S_WSTEP;
                        end else if (pr_neg_reg) begin
                            pr_neg_reg <= 1'b0;
                            wk_req_reg <= d_req_pos;
                            phase_reg <= PH_PP;
                            state_reg <= S_WSTEP;
                        end else if (pr_d_reg == max_probe_reg) begin
                            state_reg <= S_FIN;
                        end else begin
                            pr_d_reg <= pr_d_inc;
                            pr_neg_reg <= 1'b1;
                            wk_req_reg <= d_inc_req_neg;
                            phase_reg <= PH_PN;
                            state_reg <= S_WSTEP;
                        end
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_data_reg <= {3'b000, res_bad_reg, out_y, out_x, rby_reg, rbx_reg,
                                       rmy_reg, rmx_reg, res_cnt_reg, res_col_reg};
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;

endmodule
